// ===== rtl/tlg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types and codes for the toroidal life generation block: transfer
// payloads, opcodes and the command/status bundles between control and
// datapath.
// ----------------------------------------------------------------------------
package tlg_pkg;

    // Opcodes carried by an input transfer
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Row memory read address selects
    localparam logic [1:0] SEL_ITEM  = 2'd0;   // row of the latched item
    localparam logic [1:0] SEL_LAST  = 2'd1;   // bottom row (above row 0)
    localparam logic [1:0] SEL_FIRST = 2'd2;   // top row
    localparam logic [1:0] SEL_NEXT  = 2'd3;   // row below the one in work

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] row;
        logic [5:0] column;
        logic       cell_in;
    } t_in;

    typedef struct packed {
        logic cell_out;
        logic op_done;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic       cap_item;      // latch accepted transfer
        logic       rd_en;         // issue row memory read
        logic [1:0] rd_sel;        // read address select
        logic       ld_above;      // capture read row as row above
        logic       ld_cur_first;  // capture read row as current and saved top row
        logic       clr_row;       // clear row counter
        logic       adv_step;      // write next-generation row, shift window
        logic       cell_write;    // write back modified row for a cell write
        logic       out_load;      // load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       in_grid;
        logic       last_row;
        logic       out_free;
    } t_dp_status;

endpackage

// ===== rtl/tlg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_ctrl
// Sequencer for cell reads, cell writes and row-by-row generation advance.
// Drives the input stall and issues commands to the datapath.
// ----------------------------------------------------------------------------
module tlg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tlg_pkg::t_dp_status i_status,
    output tlg_pkg::t_dp_cmd    o_cmd
);
    import tlg_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_CELL_USE  = 3'd2;
    localparam logic [2:0] S_PRE_FIRST = 3'd3;
    localparam logic [2:0] S_PRE_CUR   = 3'd4;
    localparam logic [2:0] S_ADV_RD    = 3'd5;
    localparam logic [2:0] S_ADV_WR    = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.cap_item = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_status.op == OP_WRITE || i_status.op == OP_READ) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = SEL_ITEM;
                    n_state      = S_CELL_USE;
                end else if (i_status.op == OP_ADVANCE) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = SEL_LAST;
                    n_state      = S_PRE_FIRST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CELL_USE: begin
                o_cmd.cell_write = (i_status.op == OP_WRITE) && i_status.in_grid;
                n_state          = S_DONE;
            end
            S_PRE_FIRST: begin
                o_cmd.ld_above = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = SEL_FIRST;
                o_cmd.clr_row  = 1'b1;
                n_state        = S_PRE_CUR;
            end
            S_PRE_CUR: begin
                o_cmd.ld_cur_first = 1'b1;
                n_state            = S_ADV_RD;
            end
            S_ADV_RD: begin
                // bottom row takes the saved top row as its lower neighbour
                o_cmd.rd_en  = !i_status.last_row;
                o_cmd.rd_sel = SEL_NEXT;
                n_state      = S_ADV_WR;
            end
            S_ADV_WR: begin
                o_cmd.adv_step = 1'b1;
                n_state        = i_status.last_row ? S_DONE : S_ADV_RD;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV_WR && i_status.last_row) |=> (r_state == S_DONE))
        else $error("advance did not finish after the bottom row");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DISPATCH))
        else $error("accepted transfer not dispatched");

    a_write_guarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cell_write |-> (i_status.in_grid && i_status.op == OP_WRITE))
        else $error("cell write issued for a non-write or outside the grid");
`endif

endmodule

// ===== rtl/tlg_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlg_dpath
// Row memory with per-row valid bits, three-row neighbourhood window, saved
// top row, row-parallel next-generation logic and the result register.
// ----------------------------------------------------------------------------
module tlg_dpath #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlg_pkg::t_in        i_in,
    input  tlg_pkg::t_dp_cmd    i_cmd,
    output tlg_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tlg_pkg::t_out       o_out
);
    import tlg_pkg::*;

    localparam int RW = $clog2(GRID_HEIGHT);
    localparam int CW = $clog2(GRID_WIDTH);
    localparam logic [RW-1:0] LastRow = RW'(GRID_HEIGHT - 1);

    // latched item
    logic [1:0]            r_op;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         r_col;
    logic                  r_val;
    logic                  r_in_grid;

    // row memory and read port
    logic [GRID_WIDTH-1:0] r_mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] r_row_vld;
    logic [GRID_WIDTH-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic [RW-1:0]         w_rd_addr;
    logic [GRID_WIDTH-1:0] w_rd_row;

    // write port
    logic                  w_we;
    logic [RW-1:0]         w_wr_addr;
    logic [GRID_WIDTH-1:0] w_wr_data;
    logic [GRID_WIDTH-1:0] w_rmw_row;

    // generation window
    logic [GRID_WIDTH-1:0] r_above;
    logic [GRID_WIDTH-1:0] r_cur;
    logic [GRID_WIDTH-1:0] r_row0;
    logic [GRID_WIDTH-1:0] w_below;
    logic [GRID_WIDTH-1:0] w_new_row;
    logic [RW-1:0]         r_row_cnt;
    logic                  w_last;

    // result
    t_out                  r_out;
    logic                  r_out_valid;

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_op      <= i_in.opcode;
            r_row     <= RW'(i_in.row);
            r_col     <= CW'(i_in.column);
            r_val     <= i_in.cell_in;
            r_in_grid <= (32'(i_in.row) < GRID_HEIGHT) && (32'(i_in.column) < GRID_WIDTH);
        end
    end

    // Read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            SEL_ITEM:  w_rd_addr = r_row;
            SEL_LAST:  w_rd_addr = LastRow;
            SEL_FIRST: w_rd_addr = '0;
            SEL_NEXT:  w_rd_addr = r_row_cnt + RW'(1);
        endcase
    end

    // A row never written since reset reads as all dead
    assign w_rd_row = r_rd_vld ? r_rd_data : '0;

    // Read-modify-write row for a single cell write
    always_comb begin
        w_rmw_row        = w_rd_row;
        w_rmw_row[r_col] = r_val;
    end

    assign w_we      = i_cmd.adv_step || i_cmd.cell_write;
    assign w_wr_addr = i_cmd.cell_write ? r_row : r_row_cnt;
    assign w_wr_data = i_cmd.cell_write ? w_rmw_row : w_new_row;

    // Row memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Row valid bits and read valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (w_we) begin
                r_row_vld[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_row_vld[w_rd_addr];
            end
        end
    end

    // Row counter for the advance
    assign w_last = (r_row_cnt == LastRow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
        end else if (i_cmd.clr_row) begin
            r_row_cnt <= '0;
        end else if (i_cmd.adv_step && !w_last) begin
            r_row_cnt <= r_row_cnt + RW'(1);
        end
    end

    // Neighbourhood window: above / current / saved top row
    assign w_below = w_last ? r_row0 : w_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_above) begin
            r_above <= w_rd_row;
        end else if (i_cmd.adv_step) begin
            r_above <= r_cur;
        end
        if (i_cmd.ld_cur_first) begin
            r_cur  <= w_rd_row;
            r_row0 <= w_rd_row;
        end else if (i_cmd.adv_step) begin
            r_cur <= w_below;
        end
    end

    // Next-generation row, one cell per column, wrapping left and right
    for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_cell
        localparam int Lc = (c == 0) ? GRID_WIDTH - 1 : c - 1;
        localparam int Rc = (c == GRID_WIDTH - 1) ? 0 : c + 1;
        logic [3:0] w_cnt;

        assign w_cnt = 4'(r_above[Lc]) + 4'(r_above[c]) + 4'(r_above[Rc])
                     + 4'(r_cur[Lc])                    + 4'(r_cur[Rc])
                     + 4'(w_below[Lc]) + 4'(w_below[c]) + 4'(w_below[Rc]);

        assign w_new_row[c] = r_cur[c] ? (w_cnt == 4'd2 || w_cnt == 4'd3)
                                       : (w_cnt == 4'd3);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cell_out <= (r_op == OP_READ && r_in_grid) ? w_rd_row[r_col] : 1'b0;
            r_out.op_done  <= (r_op == OP_WRITE) || (r_op == OP_ADVANCE) ||
                              (r_op == OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    assign o_status.op       = r_op;
    assign o_status.in_grid  = r_in_grid;
    assign o_status.last_row = w_last;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled transfer");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row_cnt) < GRID_HEIGHT)
        else $error("row counter beyond the bottom row");

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_row_vld[$past(w_wr_addr)])
        else $error("written row not marked valid");
`endif

endmodule

// ===== rtl/toroidal_life_generation.sv =====
`timescale 1ns / 1ps
// Sequence (no output stall): a cell write or read passes DISPATCH, CELL_USE and
//   DONE before the result loads, an unused opcode DISPATCH and DONE, and an
//   advance PRE_FIRST, PRE_CUR, then ADV_RD and ADV_WR per row (single read port), then DONE.
//   The input stalls outside idle, so no new item is taken until the result loads.
// Reset: control and per-row valid bits cleared at once, so the grid reads all dead;
//   items are taken from the first cycle after reset; a held result stalls the input.
// ----------------------------------------------------------------------------
// toroidal_life_generation
// Toroidal life grid held as a row memory; cell write, cell read and a
// row-by-row one-generation advance, each giving one result transfer.
// ----------------------------------------------------------------------------
module toroidal_life_generation #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tlg_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tlg_pkg::t_out  o_out
);
    import tlg_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    tlg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Grid storage and generation logic
    tlg_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
